@@ design/tsan_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsan_pkg
// Types and constants shared by the timestamp add/normalize pipeline.
// ----------------------------------------------------------------------------
package tsan_pkg;

	localparam int unsigned DIV_STEPS = 64;
	localparam int unsigned UNIT_W    = 40;
	localparam logic [UNIT_W-1:0] PS_PER_SECOND = 40'd1000000000000;

	localparam logic [1:0] IMODE_UTC = 2'd1;
	localparam logic [1:0] IMODE_GPS = 2'd2;

	localparam logic [1:0] FMODE_SAMPLES = 2'd1;
	localparam logic [1:0] FMODE_REAL_PS = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_EPOCH  = 2'd1;
	localparam logic [1:0] ST_FRAC_DENY  = 2'd2;
	localparam logic [1:0] ST_ZERO_RATE  = 2'd3;

	typedef struct packed {
		logic [1:0]  int_mode;
		logic [1:0]  frac_mode;
		logic [31:0] stamp_seconds;
		logic [62:0] stamp_fraction;
		logic [63:0] add_seconds;
		logic [63:0] add_fraction;
		logic        fraction_requested;
	} in_item_t;

	typedef struct packed {
		logic [31:0] sum_seconds;
		logic [62:0] sum_fraction;
		logic [1:0]  status;
	} out_item_t;

	// State carried through the divider stages
	typedef struct packed {
		logic [31:0]       tsec;
		logic [62:0]       tfrac;
		logic [31:0]       asec;
		logic [1:0]        status;
		logic              pass;
		logic              neg;
		logic [UNIT_W-1:0] unit;
		logic [63:0]       da;
		logic [UNIT_W-1:0] ra;
		logic [31:0]       qa;
		logic [63:0]       dt;
		logic [UNIT_W-1:0] rt;
		logic [31:0]       qt;
	} div_state_t;

endpackage
`default_nettype wire

@@ design/time_stamp_add_normalize_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// time_stamp_add_normalize_top
// Adds signed seconds and fraction offsets to a timestamp and normalizes.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on in_valid/in_ready with an in_item_t payload,
//   results leave on out_valid/out_ready as out_item_t, one per request.
//   cfg_wr_en writes cfg_wr_data into the sample rate at once; write it
//   only while no request is in flight.
//   The pipeline has one decode stage, 64 restoring-division stages
//   (one quotient bit each, both dividends side by side) and two
//   recombine stages. A new request is taken every cycle while not stalled.
//   The whole pipeline advances together; when out_valid is high and
//   out_ready low, every stage holds and in_ready drops in the same cycle.
//   Reset clears all valid bits and the sample rate to zero.
// ----------------------------------------------------------------------------
module time_stamp_add_normalize_top import tsan_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_data,
	input  wire logic        cfg_wr_en,
	input  wire logic [39:0] cfg_wr_data
);

	logic [UNIT_W-1:0] sample_rate_q;
	logic              adv;

	div_state_t        st_s1, dec;
	logic              v_s1;
	div_state_t        dchain [0:DIV_STEPS];
	logic [DIV_STEPS:0] vchain;

	logic              v_s2;
	logic [31:0]       secs_s2;
	logic signed [41:0] f_s2;
	div_state_t        hold_s2;
	logic              v_s3;
	out_item_t         res_s3;

	logic [31:0]       q1;
	logic [41:0]       r1;
	logic [63:0]       amag;
	logic [UNIT_W-1:0] unit;
	logic [1:0]        st;
	logic              zero_add;

	assign adv      = !v_s3 || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= '0;
		end else if (cfg_wr_en) begin
			sample_rate_q <= cfg_wr_data;
		end
	end

	// decode: status, unit and dividend magnitudes
	always_comb begin
		zero_add = (in_data.add_fraction == 64'd0);
		unit = (in_data.frac_mode == FMODE_SAMPLES) ? sample_rate_q : PS_PER_SECOND;
		priority if (in_data.int_mode != IMODE_UTC && in_data.int_mode != IMODE_GPS) begin
			st = ST_BAD_EPOCH;
		end else if (in_data.fraction_requested && in_data.frac_mode != FMODE_REAL_PS
		             && in_data.frac_mode != FMODE_SAMPLES) begin
			st = ST_FRAC_DENY;
		end else if (in_data.fraction_requested && in_data.frac_mode == FMODE_SAMPLES
		             && sample_rate_q == '0) begin
			st = ST_ZERO_RATE;
		end else if (!zero_add && unit == '0) begin
			st = ST_ZERO_RATE;
		end else begin
			st = ST_OK;
		end
		amag = in_data.add_fraction[63] ? (64'd0 - in_data.add_fraction)
		                                : in_data.add_fraction;
		dec.tsec   = (st == ST_OK && zero_add)
		           ? in_data.stamp_seconds + in_data.add_seconds[31:0]
		           : in_data.stamp_seconds;
		dec.tfrac  = in_data.stamp_fraction;
		dec.asec   = in_data.add_seconds[31:0];
		dec.status = st;
		dec.pass   = (st != ST_OK) || zero_add;
		dec.neg    = in_data.add_fraction[63];
		dec.unit   = unit;
		dec.da     = amag;
		dec.ra     = '0;
		dec.qa     = '0;
		dec.dt     = {1'b0, in_data.stamp_fraction};
		dec.rt     = '0;
		dec.qt     = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1 <= dec;
		end
	end

	assign dchain[0] = st_s1;
	assign vchain[0] = v_s1;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		tsan_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.valid_in  (vchain[i]),
			.d_in      (dchain[i]),
			.valid_out (vchain[i+1]),
			.d_out     (dchain[i+1])
		);
	end

	// recombine: apply signs, sum seconds and remainders
	always_comb begin
		q1 = dchain[DIV_STEPS].neg ? (32'd0 - dchain[DIV_STEPS].qa) : dchain[DIV_STEPS].qa;
		r1 = dchain[DIV_STEPS].neg ? (42'd0 - {2'b0, dchain[DIV_STEPS].ra})
		                           : {2'b0, dchain[DIV_STEPS].ra};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s2 <= vchain[DIV_STEPS];
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hold_s2 <= dchain[DIV_STEPS];
			secs_s2 <= dchain[DIV_STEPS].tsec + dchain[DIV_STEPS].asec + q1
			         + dchain[DIV_STEPS].qt;
			f_s2    <= $signed({2'b0, dchain[DIV_STEPS].rt}) + $signed(r1);
		end
	end

	// normalize the fraction into [0, unit); passed-through items keep the decoded stamp
	always_ff @(posedge clk) begin
		if (adv) begin
			if (hold_s2.pass) begin
				res_s3.sum_seconds  <= hold_s2.tsec;
				res_s3.sum_fraction <= hold_s2.tfrac;
			end else if (f_s2 >= $signed({2'b0, hold_s2.unit})) begin
				res_s3.sum_seconds  <= secs_s2 + 32'd1;
				res_s3.sum_fraction <= {23'd0, UNIT_W'(f_s2 - $signed({2'b0, hold_s2.unit}))};
			end else if (f_s2 < 0) begin
				res_s3.sum_seconds  <= secs_s2 - 32'd1;
				res_s3.sum_fraction <= {23'd0, UNIT_W'(f_s2 + $signed({2'b0, hold_s2.unit}))};
			end else begin
				res_s3.sum_seconds  <= secs_s2;
				res_s3.sum_fraction <= {23'd0, f_s2[UNIT_W-1:0]};
			end
			res_s3.status <= hold_s2.status;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = res_s3;

endmodule
`default_nettype wire

@@ design/tsan_div_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsan_div_stage
// One registered restoring-division step for both dividends.
// ----------------------------------------------------------------------------
module tsan_div_stage import tsan_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic       valid_in,
	input  wire div_state_t d_in,
	output logic            valid_out,
	output div_state_t      d_out
);

	logic [UNIT_W:0] tra, trt;
	div_state_t      nxt;

	always_comb begin
		nxt = d_in;
		tra = {d_in.ra, d_in.da[63]};
		trt = {d_in.rt, d_in.dt[63]};
		nxt.da = {d_in.da[62:0], 1'b0};
		nxt.dt = {d_in.dt[62:0], 1'b0};
		if (tra >= {1'b0, d_in.unit}) begin
			nxt.ra = UNIT_W'(tra - {1'b0, d_in.unit});
			nxt.qa = {d_in.qa[30:0], 1'b1};
		end else begin
			nxt.ra = tra[UNIT_W-1:0];
			nxt.qa = {d_in.qa[30:0], 1'b0};
		end
		if (trt >= {1'b0, d_in.unit}) begin
			nxt.rt = UNIT_W'(trt - {1'b0, d_in.unit});
			nxt.qt = {d_in.qt[30:0], 1'b1};
		end else begin
			nxt.rt = trt[UNIT_W-1:0];
			nxt.qt = {d_in.qt[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule
`default_nettype wire

@@ design/tsan_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsan_checker
// Port-level checks on the timestamp add pipeline.
// ----------------------------------------------------------------------------
module tsan_checker import tsan_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken while output stalled");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("not ready with empty output");

endmodule

bind time_stamp_add_normalize_top tsan_checker u_tsan_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire
